// ----- design/assert_macros.svh -----
// Assertion macros shared by the numeric text scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/nts_pkg.sv -----
// Types and constants shared by the numeric text scanner modules.
`timescale 1ns / 1ps

package nts_pkg;

    typedef enum logic [3:0] {
        PH_START       = 4'd0,
        PH_AFTER_SIGN  = 4'd1,
        PH_AFTER_POINT = 4'd2,
        PH_LEAD_ZERO   = 4'd3,
        PH_SIG         = 4'd4,
        PH_NAN         = 4'd5,
        PH_INF         = 4'd6,
        PH_EXP_SIGN    = 4'd7,
        PH_EXP         = 4'd8,
        PH_DONE        = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        KIND_FINITE   = 3'd0,
        KIND_OVERFLOW = 3'd1,
        KIND_INFINITY = 3'd2,
        KIND_NAN      = 3'd3,
        KIND_ERROR    = 3'd4
    } t_kind;

    typedef struct packed {
        t_phase     phase;
        logic [1:0] progress;
        t_kind      kind;
        logic       sign;
        logic       point;
        logic       hex;
        logic       exp_neg;
    } t_ctl;

    localparam t_ctl CTL_RESET = '{
        phase:    PH_START,
        progress: 2'd0,
        kind:     KIND_FINITE,
        sign:     1'b0,
        point:    1'b0,
        hex:      1'b0,
        exp_neg:  1'b0
    };

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_POINT    = 8'h2E;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_9        = 8'h39;
    localparam logic [7:0] CH_A_UP     = 8'h41;
    localparam logic [7:0] CH_E_UP     = 8'h45;
    localparam logic [7:0] CH_F_UP     = 8'h46;
    localparam logic [7:0] CH_I_UP     = 8'h49;
    localparam logic [7:0] CH_N_UP     = 8'h4E;
    localparam logic [7:0] CH_P_UP     = 8'h50;
    localparam logic [7:0] CH_X_UP     = 8'h58;
    localparam logic [7:0] CH_A_LO     = 8'h61;
    localparam logic [7:0] CH_F_LO     = 8'h66;
    localparam logic [7:0] CH_N_LO     = 8'h6E;
    localparam logic [7:0] CH_Z_LO     = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [3:0] HEX_LETTER_BIAS = 4'd9;

endpackage

// ----- design/nts_step.sv -----
// Next-state logic of the scanner: consumes one character per beat.
`timescale 1ns / 1ps

module nts_step #(
    parameter int EXPONENT_BITS = 32
) (
    input  logic [7:0]               i_char,
    input  nts_pkg::t_ctl            i_ctl,
    input  logic [63:0]              i_acc,
    input  logic [EXPONENT_BITS-1:0] i_frac,
    input  logic [EXPONENT_BITS-1:0] i_expd,
    output nts_pkg::t_ctl            o_ctl,
    output logic [63:0]              o_acc,
    output logic [EXPONENT_BITS-1:0] o_frac,
    output logic [EXPONENT_BITS-1:0] o_expd
);

    localparam int EB = EXPONENT_BITS;
    localparam logic [EB:0] HALF = {1'b0, 1'b1, {(EB-1){1'b0}}};

    logic [7:0]    up;
    logic          is_dig;
    logic [3:0]    dval;
    logic [67:0]   dec_wide;
    logic          add_ok;
    logic [63:0]   add_acc;
    logic [EB:0]   frac_sum;
    logic [EB-1:0] frac_next;
    logic [EB+3:0] exp_wide;
    logic [EB-1:0] exp_next;
    logic [7:0]    want;
    logic          want_hit;

    assign up     = (i_char >= nts_pkg::CH_A_LO && i_char <= nts_pkg::CH_Z_LO)
                  ? i_char - nts_pkg::CASE_OFFSET : i_char;
    assign is_dig = (i_char >= nts_pkg::CH_0) && (i_char <= nts_pkg::CH_9);
    assign dval   = is_dig ? i_char[3:0] : up[3:0] + nts_pkg::HEX_LETTER_BIAS;

    // acc * 10 + d as (acc << 3) + (acc << 1) + d; any carry out is overflow
    assign dec_wide = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0} + {64'd0, dval};
    assign add_ok   = i_ctl.hex ? (i_acc[63:60] == 4'd0) : (dec_wide[67:64] == 4'd0);
    assign add_acc  = i_ctl.hex ? {i_acc[59:0], dval} : dec_wide[63:0];

    assign frac_sum  = {1'b0, i_frac} + (i_ctl.hex ? (EB+1)'(4) : (EB+1)'(1));
    assign frac_next = (frac_sum > HALF) ? HALF[EB-1:0] : frac_sum[EB-1:0];

    assign exp_wide = {1'b0, i_expd, 3'b000} + {3'b000, i_expd, 1'b0} + {{EB{1'b0}}, dval};
    assign exp_next = (exp_wide[EB+3:EB] != 4'd0) ? {EB{1'b1}} : exp_wide[EB-1:0];

    always_comb begin
        if (i_ctl.phase == nts_pkg::PH_NAN) begin
            want = (i_ctl.progress == 2'd1) ? nts_pkg::CH_A_LO : nts_pkg::CH_N_LO;
        end else begin
            want = (i_ctl.progress == 2'd1) ? nts_pkg::CH_N_LO : nts_pkg::CH_F_LO;
        end
    end

    assign want_hit = (i_char == want) || (i_char == want - nts_pkg::CASE_OFFSET);

    always_comb begin
        logic pt_req;
        logic sig_req;
        logic dig_req;
        logic dig_lead;
        pt_req   = 1'b0;
        sig_req  = 1'b0;
        dig_req  = 1'b0;
        dig_lead = 1'b0;
        o_ctl    = i_ctl;
        o_acc    = i_acc;
        o_frac   = i_frac;
        o_expd   = i_expd;
        if (i_char == nts_pkg::CH_NUL) begin
            o_ctl  = nts_pkg::CTL_RESET;
            o_acc  = '0;
            o_frac = '0;
            o_expd = '0;
        end else begin
            case (i_ctl.phase)
                nts_pkg::PH_START: begin
                    if (i_char == nts_pkg::CH_MINUS) begin
                        o_ctl.sign  = 1'b1;
                        o_ctl.phase = nts_pkg::PH_AFTER_SIGN;
                    end else if (i_char == nts_pkg::CH_PLUS) begin
                        o_ctl.phase = nts_pkg::PH_AFTER_SIGN;
                    end else if (i_char == nts_pkg::CH_POINT) begin
                        o_ctl.point = 1'b1;
                        o_ctl.phase = nts_pkg::PH_AFTER_POINT;
                    end else begin
                        pt_req = 1'b1;
                    end
                end
                nts_pkg::PH_AFTER_SIGN: begin
                    if (i_char == nts_pkg::CH_POINT) begin
                        o_ctl.point = 1'b1;
                        o_ctl.phase = nts_pkg::PH_AFTER_POINT;
                    end else begin
                        pt_req = 1'b1;
                    end
                end
                nts_pkg::PH_AFTER_POINT: begin
                    pt_req = 1'b1;
                end
                nts_pkg::PH_LEAD_ZERO: begin
                    if (up == nts_pkg::CH_X_UP) begin
                        o_ctl.hex   = 1'b1;
                        o_ctl.phase = nts_pkg::PH_SIG;
                    end else begin
                        sig_req = 1'b1;
                    end
                end
                nts_pkg::PH_SIG: begin
                    sig_req = 1'b1;
                end
                nts_pkg::PH_NAN, nts_pkg::PH_INF: begin
                    if (!want_hit) begin
                        o_ctl.phase = nts_pkg::PH_DONE;
                        o_ctl.kind  = nts_pkg::KIND_ERROR;
                    end else if (i_ctl.progress == 2'd2) begin
                        o_ctl.progress = 2'd3;
                        o_ctl.phase    = nts_pkg::PH_DONE;
                        o_ctl.kind     = (i_ctl.phase == nts_pkg::PH_NAN)
                                       ? nts_pkg::KIND_NAN : nts_pkg::KIND_INFINITY;
                    end else begin
                        o_ctl.progress = i_ctl.progress + 2'd1;
                    end
                end
                nts_pkg::PH_EXP_SIGN: begin
                    o_ctl.phase = nts_pkg::PH_EXP;
                    if (i_char == nts_pkg::CH_MINUS) begin
                        o_ctl.exp_neg = 1'b1;
                    end else if (i_char == nts_pkg::CH_PLUS) begin
                        o_ctl.exp_neg = i_ctl.exp_neg;
                    end else if (is_dig) begin
                        o_expd = {{(EB-4){1'b0}}, dval};
                    end else begin
                        o_ctl.phase = nts_pkg::PH_DONE;
                        o_ctl.kind  = nts_pkg::KIND_ERROR;
                    end
                end
                nts_pkg::PH_EXP: begin
                    if (is_dig) begin
                        o_expd = exp_next;
                    end else begin
                        o_ctl.phase = nts_pkg::PH_DONE;
                        o_ctl.kind  = nts_pkg::KIND_ERROR;
                    end
                end
                default: begin
                end
            endcase

            // start of significand: nan/inf prefix, a leading zero or any other significand character
            if (pt_req) begin
                if (up == nts_pkg::CH_N_UP) begin
                    o_ctl.phase    = nts_pkg::PH_NAN;
                    o_ctl.progress = 2'd1;
                end else if (up == nts_pkg::CH_I_UP) begin
                    o_ctl.phase    = nts_pkg::PH_INF;
                    o_ctl.progress = 2'd1;
                end else if (i_char == nts_pkg::CH_0 && !i_ctl.point) begin
                    dig_req  = 1'b1;
                    dig_lead = 1'b1;
                end else begin
                    sig_req = 1'b1;
                end
            end

            if (sig_req) begin
                if (is_dig) begin
                    dig_req = 1'b1;
                end else if (up >= nts_pkg::CH_A_UP && up <= nts_pkg::CH_F_UP) begin
                    if (i_ctl.hex) begin
                        dig_req = 1'b1;
                    end else if (up == nts_pkg::CH_E_UP) begin
                        o_ctl.phase = nts_pkg::PH_EXP_SIGN;
                    end else begin
                        o_ctl.phase = nts_pkg::PH_DONE;
                        o_ctl.kind  = nts_pkg::KIND_ERROR;
                    end
                end else if (i_char == nts_pkg::CH_POINT && !i_ctl.point) begin
                    o_ctl.point = 1'b1;
                    o_ctl.phase = nts_pkg::PH_SIG;
                end else if (up == nts_pkg::CH_P_UP && i_ctl.hex) begin
                    o_ctl.phase = nts_pkg::PH_EXP_SIGN;
                end else begin
                    o_ctl.phase = nts_pkg::PH_DONE;
                    o_ctl.kind  = nts_pkg::KIND_ERROR;
                end
            end

            if (dig_req) begin
                if (!add_ok) begin
                    o_ctl.phase = nts_pkg::PH_DONE;
                    o_ctl.kind  = nts_pkg::KIND_OVERFLOW;
                end else begin
                    o_acc = add_acc;
                    if (i_ctl.point) begin
                        o_frac = frac_next;
                    end
                    o_ctl.phase = dig_lead ? nts_pkg::PH_LEAD_ZERO : nts_pkg::PH_SIG;
                end
            end
        end
    end

endmodule

// ----- design/nts_result.sv -----
// Result formatting: final kind, exponent combine and saturation, zeroing.
`timescale 1ns / 1ps

module nts_result #(
    parameter int EXPONENT_BITS = 32
) (
    input  nts_pkg::t_ctl            i_ctl,
    input  logic [63:0]              i_acc,
    input  logic [EXPONENT_BITS-1:0] i_frac,
    input  logic [EXPONENT_BITS-1:0] i_expd,
    output nts_pkg::t_kind           o_kind,
    output logic                     o_negative,
    output logic [63:0]              o_significand,
    output logic                     o_hex_base,
    output logic [EXPONENT_BITS-1:0] o_exponent
);

    localparam int EB = EXPONENT_BITS;
    localparam logic [EB:0] HALF = {1'b0, 1'b1, {(EB-1){1'b0}}};

    logic [EB:0]   mag_sum;
    logic [EB:0]   mag_neg;
    logic [EB:0]   neg_val;
    logic [EB-1:0] diff;
    logic [EB-1:0] pos_val;
    logic [EB-1:0] expo;
    logic          finite;

    // negative written exponent: -(frac + exp), clamped at the signed minimum
    assign mag_sum = {1'b0, i_frac} + {1'b0, i_expd};
    assign mag_neg = (mag_sum > HALF) ? HALF : mag_sum;
    assign neg_val = {(EB+1){1'b0}} - mag_neg;

    // positive written exponent: exp - frac, clamped at the signed maximum
    assign diff    = i_expd - i_frac;
    assign pos_val = (i_expd >= i_frac && diff[EB-1]) ? {1'b0, {(EB-1){1'b1}}} : diff;
    assign expo    = i_ctl.exp_neg ? neg_val[EB-1:0] : pos_val;

    always_comb begin
        if (i_ctl.phase == nts_pkg::PH_NAN || i_ctl.phase == nts_pkg::PH_INF) begin
            o_kind = nts_pkg::KIND_ERROR;
        end else begin
            o_kind = i_ctl.kind;
        end
    end

    assign finite        = (o_kind == nts_pkg::KIND_FINITE);
    assign o_negative    = i_ctl.sign;
    assign o_significand = finite ? i_acc : 64'd0;
    assign o_hex_base    = finite & i_ctl.hex;
    assign o_exponent    = finite ? expo : {EB{1'b0}};

endmodule

// ----- design/numeric_text_scanner.sv -----
// Top level of the numeric text scanner: input register, scan state, result register.
//
//  channel  | valid         | ready         | payload
//  ---------+---------------+---------------+--------------------------------------------
//  char in  | i_char_valid  | o_char_ready  | i_char_code
//  result   | o_res_valid   | i_res_ready   | o_kind, o_negative, o_significand,
//           |               |               | o_hex_base, o_exponent
//
// One character beat per cycle unless a zero byte is held up; each character passes
// through the input register and is folded into the scan state by one step of logic.
// The result register loads when the zero byte leaves the input register.
// Reset is synchronous; there is no clearing pass.
// Only a zero byte waits on the result register: it holds in the input
// register while a previous result is still untaken, which backs up the input.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module numeric_text_scanner #(
    parameter int EXPONENT_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_char_valid,
    output logic                     o_char_ready,
    input  logic [7:0]               i_char_code,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output logic [2:0]               o_kind,
    output logic                     o_negative,
    output logic [63:0]              o_significand,
    output logic                     o_hex_base,
    output logic [EXPONENT_BITS-1:0] o_exponent
);

    localparam int EB = EXPONENT_BITS;
    localparam logic [EB-1:0] HALF = {1'b1, {(EB-1){1'b0}}};

    logic                 r_in_vld;
    logic [7:0]           r_in_char;
    nts_pkg::t_ctl        r_ctl;
    logic [63:0]          r_acc;
    logic [EB-1:0]        r_frac;
    logic [EB-1:0]        r_expd;
    logic                 r_res_vld;
    nts_pkg::t_kind       r_kind;
    logic                 r_neg;
    logic [63:0]          r_sig;
    logic                 r_hexb;
    logic [EB-1:0]        r_exp;

    nts_pkg::t_ctl        n_ctl;
    logic [63:0]          n_acc;
    logic [EB-1:0]        n_frac;
    logic [EB-1:0]        n_expd;
    nts_pkg::t_kind       n_kind;
    logic                 n_neg;
    logic [63:0]          n_sig;
    logic                 n_hexb;
    logic [EB-1:0]        n_exp;

    logic                 is_term;
    logic                 advance;
    logic                 fire;
    logic                 term_fire;

    assign is_term      = (r_in_char == nts_pkg::CH_NUL);
    assign advance      = !is_term || !r_res_vld || i_res_ready;
    assign fire         = r_in_vld && advance;
    assign term_fire    = fire && is_term;
    assign o_char_ready = !r_in_vld || advance;

    nts_step #(
        .EXPONENT_BITS (EB)
    ) u_step (
        .i_char (r_in_char),
        .i_ctl  (r_ctl),
        .i_acc  (r_acc),
        .i_frac (r_frac),
        .i_expd (r_expd),
        .o_ctl  (n_ctl),
        .o_acc  (n_acc),
        .o_frac (n_frac),
        .o_expd (n_expd)
    );

    nts_result #(
        .EXPONENT_BITS (EB)
    ) u_result (
        .i_ctl         (r_ctl),
        .i_acc         (r_acc),
        .i_frac        (r_frac),
        .i_expd        (r_expd),
        .o_kind        (n_kind),
        .o_negative    (n_neg),
        .o_significand (n_sig),
        .o_hex_base    (n_hexb),
        .o_exponent    (n_exp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_char_ready) begin
            r_in_vld <= i_char_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_char_ready && i_char_valid) begin
            r_in_char <= i_char_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= nts_pkg::CTL_RESET;
            r_acc  <= '0;
            r_frac <= '0;
            r_expd <= '0;
        end else if (fire) begin
            r_ctl  <= n_ctl;
            r_acc  <= n_acc;
            r_frac <= n_frac;
            r_expd <= n_expd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (term_fire) begin
            r_res_vld <= 1'b1;
        end else if (i_res_ready) begin
            r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (term_fire) begin
            r_kind <= n_kind;
            r_neg  <= n_neg;
            r_sig  <= n_sig;
            r_hexb <= n_hexb;
            r_exp  <= n_exp;
        end
    end

    assign o_res_valid   = r_res_vld;
    assign o_kind        = r_kind;
    assign o_negative    = r_neg;
    assign o_significand = r_sig;
    assign o_hex_base    = r_hexb;
    assign o_exponent    = r_exp;

    `NTS_ASSERT_NEXT(a_term_clears_state, i_clk, i_rst_n, term_fire, r_ctl.phase == nts_pkg::PH_START && r_acc == 64'd0 && r_frac == '0 && r_expd == '0, "scan state not cleared after terminator")
    `NTS_ASSERT_NOW(a_done_has_kind, i_clk, i_rst_n, r_ctl.phase == nts_pkg::PH_DONE, r_ctl.kind != nts_pkg::KIND_FINITE, "decided phase without a decided kind")
    `NTS_ASSERT_NOW(a_kind_only_when_done, i_clk, i_rst_n, r_ctl.phase != nts_pkg::PH_DONE, r_ctl.kind == nts_pkg::KIND_FINITE, "kind decided while still scanning")
    `NTS_ASSERT_NOW(a_frac_saturated, i_clk, i_rst_n, 1'b1, r_frac <= HALF, "fraction shift beyond saturation limit")
    `NTS_ASSERT_NOW(a_nonfinite_zeroed, i_clk, i_rst_n, o_res_valid && o_kind != nts_pkg::KIND_FINITE, o_significand == 64'd0 && o_exponent == '0 && !o_hex_base, "non-finite result carries numeric fields")

endmodule

// ----- tb/numeric_text_scanner_tb.sv -----
// Self-checking testbench for numeric_text_scanner: text strings in, scanned numbers checked.
`timescale 1ns / 1ps

module numeric_text_scanner_tb;

    localparam int          EXP_W       = 32;
    localparam logic [63:0] EXP_HALF    = 64'd1 << (EXP_W - 1);
    localparam logic [63:0] EXP_FULL    = EXP_HALF - 64'd1 + EXP_HALF;
    localparam int          CYCLE_LIMIT = 500_000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          ITEM_TARGET = 2000;

    typedef struct packed {
        nts_pkg::t_kind   kind;
        logic             neg;
        logic [63:0]      sig;
        logic             hex;
        logic [EXP_W-1:0] expo;
    } t_num;

    typedef struct packed {
        logic fixed;
        t_num res;
    } t_pinned;

    typedef struct {
        string text;
        logic  fixed;
        t_num  res;
    } t_text_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_char_valid;
    logic             o_char_ready;
    logic [7:0]       i_char_code;
    logic             o_res_valid;
    logic             i_res_ready;
    logic [2:0]       o_kind;
    logic             o_negative;
    logic [63:0]      o_significand;
    logic             o_hex_base;
    logic [EXP_W-1:0] o_exponent;

    t_num    expected_numbers [$];
    t_pinned pinned_numbers [$];
    int      fault_count   = 0;
    int      strings_total = 0;
    int      results_seen  = 0;
    int      sent_items    = 0;
    bit      hold_go       = 1'b0;
    bit      hold_done     = 1'b0;
    bit [31:0] cycle_count = '0;
    wire     calm = &cycle_count[9:8];

    // scanner state mirror
    nts_pkg::t_phase ph;
    logic [1:0]      prog;
    nts_pkg::t_kind  dk;
    logic            sg, pt, hx, en;
    logic [63:0]     acc, frac, edig;

    t_text_row dir_rows [25] = '{
        '{"",          1'b1, '{nts_pkg::KIND_FINITE,   1'b0, 64'd0, 1'b0, 32'd0}},
        '{"-",         1'b1, '{nts_pkg::KIND_FINITE,   1'b1, 64'd0, 1'b0, 32'd0}},
        '{".",         1'b1, '{nts_pkg::KIND_FINITE,   1'b0, 64'd0, 1'b0, 32'd0}},
        '{"0x",        1'b1, '{nts_pkg::KIND_FINITE,   1'b0, 64'd0, 1'b1, 32'd0}},
        '{"1e-",       1'b1, '{nts_pkg::KIND_FINITE,   1'b0, 64'd1, 1'b0, 32'd0}},
        '{"nan",       1'b1, '{nts_pkg::KIND_NAN,      1'b0, 64'd0, 1'b0, 32'd0}},
        '{"-NaN(12)",  1'b1, '{nts_pkg::KIND_NAN,      1'b1, 64'd0, 1'b0, 32'd0}},
        '{"+inFinity", 1'b1, '{nts_pkg::KIND_INFINITY, 1'b0, 64'd0, 1'b0, 32'd0}},
        '{"in",        1'b1, '{nts_pkg::KIND_ERROR,    1'b0, 64'd0, 1'b0, 32'd0}},
        '{"nax",       1'b1, '{nts_pkg::KIND_ERROR,    1'b0, 64'd0, 1'b0, 32'd0}},
        '{"18446744073709551615", 1'b1,
            '{nts_pkg::KIND_FINITE, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0}},
        '{"18446744073709551616", 1'b1,
            '{nts_pkg::KIND_OVERFLOW, 1'b0, 64'd0, 1'b0, 32'd0}},
        '{"-0XffffFFFFffffFFFF", 1'b1,
            '{nts_pkg::KIND_FINITE, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'd0}},
        '{"0x10000000000000000", 1'b1,
            '{nts_pkg::KIND_OVERFLOW, 1'b0, 64'd0, 1'b0, 32'd0}},
        '{"1e99999999999", 1'b1,
            '{nts_pkg::KIND_FINITE, 1'b0, 64'd1, 1'b0, 32'h7FFF_FFFF}},
        '{"-1E-99999999999", 1'b1,
            '{nts_pkg::KIND_FINITE, 1'b1, 64'd1, 1'b0, 32'h8000_0000}},
        '{"e5",        1'b1, '{nts_pkg::KIND_FINITE,   1'b0, 64'd0, 1'b0, 32'd5}},
        '{".0x1",      1'b1, '{nts_pkg::KIND_ERROR,    1'b0, 64'd0, 1'b0, 32'd0}},
        '{"1..2",      1'b1, '{nts_pkg::KIND_ERROR,    1'b0, 64'd0, 1'b0, 32'd0}},
        '{"7\200",     1'b1, '{nts_pkg::KIND_ERROR,    1'b0, 64'd0, 1'b0, 32'd0}},
        '{"\377",      1'b1, '{nts_pkg::KIND_ERROR,    1'b0, 64'd0, 1'b0, 32'd0}},
        '{"1e+x",      1'b1, '{nts_pkg::KIND_ERROR,    1'b0, 64'd0, 1'b0, 32'd0}},
        '{"0x1.8p-3",  1'b0, '0},
        '{"0x1e",      1'b0, '0},
        '{".5E-2",     1'b0, '0}
    };

    numeric_text_scanner #(
        .EXPONENT_BITS(EXP_W)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_char_valid  (i_char_valid),
        .o_char_ready  (o_char_ready),
        .i_char_code   (i_char_code),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .o_kind        (o_kind),
        .o_negative    (o_negative),
        .o_significand (o_significand),
        .o_hex_base    (o_hex_base),
        .o_exponent    (o_exponent)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("numeric_text_scanner regression: fail");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic void lex_clear();
        ph   = nts_pkg::PH_START;
        prog = 2'd0;
        dk   = nts_pkg::KIND_FINITE;
        sg   = 1'b0;
        pt   = 1'b0;
        hx   = 1'b0;
        en   = 1'b0;
        acc  = '0;
        frac = '0;
        edig = '0;
    endfunction

    function automatic void lex_settle(input nts_pkg::t_kind k);
        dk = k;
        ph = nts_pkg::PH_DONE;
    endfunction

    function automatic void lex_digit(input logic [63:0] d);
        if (hx) begin
            if (acc[63:60] != 4'd0) begin
                lex_settle(nts_pkg::KIND_OVERFLOW);
                return;
            end
            acc = {acc[59:0], d[3:0]};
        end else begin
            if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
                lex_settle(nts_pkg::KIND_OVERFLOW);
                return;
            end
            acc = acc * 64'd10 + d;
        end
        if (pt) begin
            frac = frac + (hx ? 64'd4 : 64'd1);
            if (frac > EXP_HALF) frac = EXP_HALF;
        end
        ph = nts_pkg::PH_SIG;
    endfunction

    function automatic void lex_body(input byte unsigned c);
        byte unsigned u;
        u = (c >= nts_pkg::CH_A_LO && c <= nts_pkg::CH_Z_LO)
          ? c - nts_pkg::CASE_OFFSET : c;
        if (c >= nts_pkg::CH_0 && c <= nts_pkg::CH_9) begin
            lex_digit(64'(c - nts_pkg::CH_0));
        end else if (u >= nts_pkg::CH_A_UP && u <= nts_pkg::CH_F_UP) begin
            if (hx) lex_digit(64'(u - nts_pkg::CH_A_UP + 8'd10));
            else if (u == nts_pkg::CH_E_UP) ph = nts_pkg::PH_EXP_SIGN;
            else lex_settle(nts_pkg::KIND_ERROR);
        end else if (c == nts_pkg::CH_POINT && !pt) begin
            pt = 1'b1;
            ph = nts_pkg::PH_SIG;
        end else if (u == nts_pkg::CH_P_UP && hx) begin
            ph = nts_pkg::PH_EXP_SIGN;
        end else begin
            lex_settle(nts_pkg::KIND_ERROR);
        end
    endfunction

    function automatic void lex_front(input byte unsigned c, input bit point_ok);
        if (point_ok && c == nts_pkg::CH_POINT) begin
            pt = 1'b1;
            ph = nts_pkg::PH_AFTER_POINT;
        end else if ((c | nts_pkg::CASE_OFFSET) == nts_pkg::CH_N_LO) begin
            ph   = nts_pkg::PH_NAN;
            prog = 2'd1;
        end else if ((c | nts_pkg::CASE_OFFSET) == (nts_pkg::CH_I_UP | nts_pkg::CASE_OFFSET)) begin
            ph   = nts_pkg::PH_INF;
            prog = 2'd1;
        end else if (c == nts_pkg::CH_0 && !pt) begin
            lex_digit(64'd0);
            if (ph == nts_pkg::PH_SIG) ph = nts_pkg::PH_LEAD_ZERO;
        end else begin
            lex_body(c);
        end
    endfunction

    function automatic void lex_prefix(input byte unsigned c, input byte unsigned second,
                                       input byte unsigned third, input nts_pkg::t_kind k);
        byte unsigned want;
        want = (prog == 2'd1) ? second : third;
        if (c == want || c == want - nts_pkg::CASE_OFFSET) begin
            prog = prog + 2'd1;
            if (prog == 2'd3) lex_settle(k);
        end else begin
            lex_settle(nts_pkg::KIND_ERROR);
        end
    endfunction

    function automatic logic [EXP_W-1:0] lex_exponent();
        logic [63:0] mag;
        if (en) begin
            mag = frac + edig;
            if (mag < frac || mag > EXP_HALF) mag = EXP_HALF;
            return EXP_W'(64'd0 - mag);
        end
        if (edig >= frac) begin
            mag = edig - frac;
            if (mag > EXP_HALF - 64'd1) mag = EXP_HALF - 64'd1;
            return EXP_W'(mag);
        end
        return EXP_W'(64'd0 - (frac - edig));
    endfunction

    // returns 1 when the character ends the string and res holds the number
    function automatic bit lex_char(input byte unsigned c, output t_num res);
        nts_pkg::t_kind k;
        logic [63:0]    d;
        res = '0;
        if (c == nts_pkg::CH_NUL) begin
            k = dk;
            if (ph == nts_pkg::PH_NAN || ph == nts_pkg::PH_INF) k = nts_pkg::KIND_ERROR;
            res.kind = k;
            res.neg  = sg;
            if (k == nts_pkg::KIND_FINITE) begin
                res.sig  = acc;
                res.hex  = hx;
                res.expo = lex_exponent();
            end
            lex_clear();
            return 1'b1;
        end
        d = 64'(c - nts_pkg::CH_0);
        case (ph)
            nts_pkg::PH_START: begin
                if (c == nts_pkg::CH_MINUS) begin
                    sg = 1'b1;
                    ph = nts_pkg::PH_AFTER_SIGN;
                end else if (c == nts_pkg::CH_PLUS) begin
                    ph = nts_pkg::PH_AFTER_SIGN;
                end else begin
                    lex_front(c, 1'b1);
                end
            end
            nts_pkg::PH_AFTER_SIGN:  lex_front(c, 1'b1);
            nts_pkg::PH_AFTER_POINT: lex_front(c, 1'b0);
            nts_pkg::PH_LEAD_ZERO: begin
                if ((c | nts_pkg::CASE_OFFSET) == (nts_pkg::CH_X_UP | nts_pkg::CASE_OFFSET)) begin
                    hx = 1'b1;
                    ph = nts_pkg::PH_SIG;
                end else begin
                    lex_body(c);
                end
            end
            nts_pkg::PH_SIG: lex_body(c);
            nts_pkg::PH_NAN:
                lex_prefix(c, nts_pkg::CH_A_LO, nts_pkg::CH_N_LO, nts_pkg::KIND_NAN);
            nts_pkg::PH_INF:
                lex_prefix(c, nts_pkg::CH_N_LO, nts_pkg::CH_F_LO, nts_pkg::KIND_INFINITY);
            nts_pkg::PH_EXP_SIGN: begin
                if (c == nts_pkg::CH_MINUS) begin
                    en = 1'b1;
                    ph = nts_pkg::PH_EXP;
                end else if (c == nts_pkg::CH_PLUS) begin
                    ph = nts_pkg::PH_EXP;
                end else if (c >= nts_pkg::CH_0 && c <= nts_pkg::CH_9) begin
                    edig = d;
                    ph   = nts_pkg::PH_EXP;
                end else begin
                    lex_settle(nts_pkg::KIND_ERROR);
                end
            end
            nts_pkg::PH_EXP: begin
                if (c >= nts_pkg::CH_0 && c <= nts_pkg::CH_9) begin
                    if (edig > (EXP_FULL - d) / 64'd10) edig = EXP_FULL;
                    else edig = edig * 64'd10 + d;
                end else begin
                    lex_settle(nts_pkg::KIND_ERROR);
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // ---------------- checking ----------------

    task automatic flag(input string what, input logic [63:0] got, input logic [63:0] want);
        fault_count++;
        $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_num    lexed;
        t_num    want;
        t_pinned pin;
        if (i_rst_n) begin
            if (i_char_valid && o_char_ready) begin
                if (lex_char(i_char_code, lexed)) begin
                    pin = pinned_numbers.pop_front();
                    expected_numbers.push_back(pin.fixed ? pin.res : lexed);
                end
            end
            if (o_res_valid && i_res_ready) begin
                results_seen++;
                if (expected_numbers.size() == 0) begin
                    flag("unexpected result beat", 64'(o_kind), 64'd0);
                end else begin
                    want = expected_numbers.pop_front();
                    if (o_kind !== want.kind)        flag("kind", 64'(o_kind), 64'(want.kind));
                    if (o_negative !== want.neg)     flag("negative", 64'(o_negative), 64'(want.neg));
                    if (o_significand !== want.sig)  flag("significand", o_significand, want.sig);
                    if (o_hex_base !== want.hex)     flag("hex_base", 64'(o_hex_base), 64'(want.hex));
                    if (o_exponent !== want.expo)    flag("exponent", 64'(o_exponent), 64'(want.expo));
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic byte unsigned flip_case(input byte unsigned c);
        return $urandom_range(0, 1) ? (c ^ nts_pkg::CASE_OFFSET) : c;
    endfunction

    function automatic int span(input int wide);
        int r;
        r = $urandom_range(0, 19);
        if (r < 15) return $urandom_range(0, 4);
        if (r < 18) return $urandom_range(5, 10);
        return $urandom_range(wide - 2, wide + 1);
    endfunction

    function automatic void put_digits(ref byte unsigned t[$], input int n, input bit hex_digits);
        int v;
        for (int k = 0; k < n; k++) begin
            v = hex_digits ? $urandom_range(0, 15) : $urandom_range(0, 9);
            if (v < 10) t.push_back(8'(nts_pkg::CH_0 + v));
            else t.push_back(flip_case(8'(nts_pkg::CH_A_UP + v - 10)));
        end
    endfunction

    function automatic void put_sign(ref byte unsigned t[$]);
        int s;
        s = $urandom_range(0, 3);
        if (s == 0) t.push_back(nts_pkg::CH_MINUS);
        else if (s == 1) t.push_back(nts_pkg::CH_PLUS);
    endfunction

    function automatic void make_text(ref byte unsigned t[$]);
        int    pick;
        int    n;
        bit    hex_text;
        bit    lead_point;
        string w;
        pick = $urandom_range(0, 99);
        t.delete();
        if (pick >= 90) begin
            n = $urandom_range(0, 6);
            repeat (n) t.push_back(8'($urandom_range(1, 255)));
            return;
        end
        put_sign(t);
        if (pick < 15) begin
            if ($urandom_range(0, 1)) w = "nan";
            else w = "infinity";
            if ($urandom_range(0, 3) == 0) n = $urandom_range(1, 2);
            else n = $urandom_range(0, 1) ? 3 : w.len();
            for (int k = 0; k < n; k++) t.push_back(flip_case(w[k]));
            n = $urandom_range(0, 2);
            repeat (n) t.push_back(8'($urandom_range(1, 127)));
        end else begin
            hex_text   = pick >= 55;
            lead_point = !hex_text && $urandom_range(0, 4) == 0;
            if (hex_text) begin
                t.push_back(nts_pkg::CH_0);
                t.push_back(flip_case(nts_pkg::CH_X_UP));
            end else if (lead_point) begin
                t.push_back(nts_pkg::CH_POINT);
            end else if ($urandom_range(0, 4) == 0) begin
                t.push_back(nts_pkg::CH_0);
            end
            put_digits(t, span(hex_text ? 16 : 20), hex_text);
            if (!lead_point && $urandom_range(0, 1)) begin
                t.push_back(nts_pkg::CH_POINT);
                put_digits(t, span(6), hex_text);
            end
            if ($urandom_range(0, 1)) begin
                t.push_back(flip_case(hex_text ? nts_pkg::CH_P_UP : nts_pkg::CH_E_UP));
                put_sign(t);
                put_digits(t, span(11), 1'b0);
            end
        end
        // occasional corrupted character
        if ($urandom_range(0, 9) == 0 && t.size() != 0)
            t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(1, 255));
    endfunction

    task automatic send_text(input byte unsigned txt[$], input logic fixed, input t_num res);
        int gap;
        pinned_numbers.push_back('{fixed, res});
        txt.push_back(nts_pkg::CH_NUL);
        strings_total++;
        foreach (txt[k]) begin
            i_char_valid <= 1'b1;
            i_char_code  <= txt[k];
            do @(posedge i_clk); while (!o_char_ready);
            sent_items++;
            gap = idle_len();
            if (gap != 0) begin
                i_char_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        int gap;
        i_res_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                i_res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                gap = idle_len();
                if (gap == 0) begin
                    i_res_ready <= 1'b1;
                end else begin
                    i_res_ready <= 1'b0;
                    repeat (gap - 1) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        byte unsigned txt [$];
        i_rst_n      <= 1'b0;
        i_char_valid <= 1'b0;
        i_char_code  <= '0;
        lex_clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            txt.delete();
            for (int k = 0; k < dir_rows[r].text.len(); k++) txt.push_back(dir_rows[r].text[k]);
            send_text(txt, dir_rows[r].fixed, dir_rows[r].res);
        end

        // result side stalls for a long stretch while text keeps coming
        hold_go = 1'b1;
        while (sent_items < ITEM_TARGET) begin
            make_text(txt);
            send_text(txt, 1'b0, '0);
        end
        i_char_valid <= 1'b0;

        while (results_seen < strings_total) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (expected_numbers.size() != 0)
            flag("missing result", 64'(expected_numbers.size()), 64'd0);
        if (fault_count == 0)
            $display("numeric_text_scanner regression: pass");
        else
            $display("numeric_text_scanner regression: fail");
        $finish;
    end

endmodule
